### hw/rtl/hmac_sha1_engine_macros.svh
// Assertion macros used by the checker file of the engine.
`ifndef HMAC_SHA1_ENGINE_MACROS_SVH
`define HMAC_SHA1_ENGINE_MACROS_SVH

// Checked on every clock edge outside of reset.
`define HS1E_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define HS1E_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### hw/rtl/hs1e_pkg.sv
package hs1e_pkg;

    localparam int WORD_BITS    = 32;
    localparam int BUF_DEPTH    = 16;
    localparam int KEY_WORDS    = 8;
    localparam int KEY_BITS     = 64;
    localparam int CFG_IDX_BITS = 4;
    localparam int LEN_BITS_DEF = 64;
    localparam int ROUNDS       = 80;

    localparam logic [31:0] IPAD = 32'h36363636;
    localparam logic [31:0] OPAD = 32'h5C5C5C5C;

    localparam logic [31:0] IV0 = 32'h67452301;
    localparam logic [31:0] IV1 = 32'hEFCDAB89;
    localparam logic [31:0] IV2 = 32'h98BADCFE;
    localparam logic [31:0] IV3 = 32'h10325476;
    localparam logic [31:0] IV4 = 32'hC3D2E1F0;

    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;

    // Bit length of the outer message: 64 pad bytes plus a 20-byte digest.
    localparam logic [31:0] OUTER_LEN = 32'd672;
    localparam logic [31:0] PAD_WORD  = 32'h80000000;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       last;
    } t_in;

    typedef struct packed {
        logic [31:0] digest_word;
        logic        last_word;
    } t_out;

    typedef enum logic [3:0] {
        S_IDLE,
        S_KEY,
        S_BYTE,
        S_PAD,
        S_ZERO,
        S_LEN,
        S_INNER,
        S_OTAIL,
        S_CPRE,
        S_COMP,
        S_CADD,
        S_OUT
    } t_state;

endpackage

### hw/rtl/hs1e_ram.sv
module hs1e_ram #(
    parameter int WIDTH = hs1e_pkg::WORD_BITS,
    parameter int DEPTH = hs1e_pkg::BUF_DEPTH
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/hmac_sha1_engine.sv
// Byte item: accepted while idle, then absorbed into the block memory.
// Every 64th byte adds one compression (load, 80 rounds, add).
// First item of a message adds the 16 writes of the ipad block plus one compression.
// Last item adds padding writes, one or two inner compressions, the opad and tail
// blocks (16 writes and one compression each), then five output words.
// Reset is synchronous, active low: control, chain, key registers and the started flag clear.
module hmac_sha1_engine #(
    parameter int LENGTH_COUNTER_BITS = hs1e_pkg::LEN_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  hs1e_pkg::t_in                     i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output hs1e_pkg::t_out                    o_out_data,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [hs1e_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [hs1e_pkg::KEY_BITS-1:0]     i_cfg_data
);

    localparam int L = LENGTH_COUNTER_BITS;

    hs1e_pkg::t_state r_state, n_state, r_ret, n_ret;
    hs1e_pkg::t_in    r_item, n_item;

    logic [hs1e_pkg::KEY_BITS-1:0] r_key [hs1e_pkg::KEY_WORDS];
    logic [31:0] r_chain [5];
    logic [31:0] n_chain [5];
    logic [31:0] r_inner [5];
    logic [31:0] n_inner [5];
    logic [31:0] r_win [16];
    logic [31:0] n_win [16];
    logic [31:0] r_a, r_b, r_c, r_d, r_e, n_a, n_b, n_c, n_d, n_e;
    logic [31:0] r_acc, n_acc;
    logic [L-1:0] r_cnt, n_cnt;
    logic [6:0]  r_round, n_round;
    logic [4:0]  r_widx, n_widx;
    logic [3:0]  r_zlim, n_zlim;
    logic [2:0]  r_oidx, n_oidx;
    logic        r_started, n_started;
    logic        r_opad, n_opad;

    logic        ram_we;
    logic [3:0]  ram_waddr, ram_raddr;
    logic [31:0] ram_wdata, ram_rdata;

    logic [31:0] sched, w_new, f, k, t_sum, byte_word, key_half, pad_val;
    logic [L-1:0] cnt_inc, len_sum, len_bits;
    logic [63:0] len64;
    logic [5:0]  pos;

    hs1e_ram #(
        .WIDTH(hs1e_pkg::WORD_BITS),
        .DEPTH(hs1e_pkg::BUF_DEPTH)
    ) u_buf (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    // Key registers, written only while idle.
    assign o_cfg_ready = (r_state == hs1e_pkg::S_IDLE);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < hs1e_pkg::KEY_WORDS; i++) begin
                r_key[i] <= '0;
            end
        end else if (i_cfg_valid && o_cfg_ready &&
                     i_cfg_index < hs1e_pkg::CFG_IDX_BITS'(hs1e_pkg::KEY_WORDS)) begin
            r_key[i_cfg_index[2:0]] <= i_cfg_data;
        end
    end

    // Datapath helpers.
    assign pos       = r_cnt[5:0];
    assign cnt_inc   = r_cnt + L'(1);
    assign len_sum   = r_cnt + L'(64);
    assign len_bits  = {len_sum[L-4:0], 3'b000};
    assign len64     = 64'(len_bits);
    assign byte_word = {r_item.data_byte, 24'h0} >> {pos[1:0], 3'b000};
    assign pad_val   = r_opad ? hs1e_pkg::OPAD : hs1e_pkg::IPAD;
    assign key_half  = r_widx[0] ? r_key[r_widx[3:1]][31:0] : r_key[r_widx[3:1]][63:32];
    assign sched     = r_win[13] ^ r_win[8] ^ r_win[2] ^ r_win[0];
    assign w_new     = (r_round < 7'd16) ? ram_rdata : {sched[30:0], sched[31]};

    // Round function and constant by round range.
    always_comb begin
        if (r_round < 7'd20) begin
            f = (r_b & r_c) | (~r_b & r_d);
            k = hs1e_pkg::K0;
        end else if (r_round < 7'd40) begin
            f = r_b ^ r_c ^ r_d;
            k = hs1e_pkg::K1;
        end else if (r_round < 7'd60) begin
            f = (r_b & r_c) | (r_b & r_d) | (r_c & r_d);
            k = hs1e_pkg::K2;
        end else begin
            f = r_b ^ r_c ^ r_d;
            k = hs1e_pkg::K3;
        end
    end
    assign t_sum = {r_a[26:0], r_a[31:27]} + f + r_e + w_new + k;

    // Handshake outputs.
    assign o_in_stall  = (r_state != hs1e_pkg::S_IDLE);
    assign o_out_valid = (r_state == hs1e_pkg::S_OUT);
    always_comb begin
        o_out_data.digest_word = r_chain[r_oidx];
        o_out_data.last_word   = (r_oidx == 3'd4);
    end

    // State register and control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= hs1e_pkg::S_IDLE;
            r_ret     <= hs1e_pkg::S_IDLE;
            r_started <= 1'b0;
            r_cnt     <= '0;
            r_acc     <= '0;
            r_chain   <= '{hs1e_pkg::IV0, hs1e_pkg::IV1, hs1e_pkg::IV2,
                           hs1e_pkg::IV3, hs1e_pkg::IV4};
            r_oidx    <= '0;
        end else begin
            r_state   <= n_state;
            r_ret     <= n_ret;
            r_started <= n_started;
            r_cnt     <= n_cnt;
            r_acc     <= n_acc;
            r_chain   <= n_chain;
            r_oidx    <= n_oidx;
        end
    end

    // Payload and working registers.
    always_ff @(posedge i_clk) begin
        r_item  <= n_item;
        r_inner <= n_inner;
        r_win   <= n_win;
        r_a     <= n_a;
        r_b     <= n_b;
        r_c     <= n_c;
        r_d     <= n_d;
        r_e     <= n_e;
        r_round <= n_round;
        r_widx  <= n_widx;
        r_zlim  <= n_zlim;
        r_opad  <= n_opad;
    end

    // Next state, memory port and datapath updates.
    always_comb begin
        n_state   = r_state;
        n_ret     = r_ret;
        n_item    = r_item;
        n_started = r_started;
        n_cnt     = r_cnt;
        n_acc     = r_acc;
        n_chain   = r_chain;
        n_inner   = r_inner;
        n_win     = r_win;
        n_a       = r_a;
        n_b       = r_b;
        n_c       = r_c;
        n_d       = r_d;
        n_e       = r_e;
        n_round   = r_round;
        n_widx    = r_widx;
        n_zlim    = r_zlim;
        n_oidx    = r_oidx;
        n_opad    = r_opad;
        ram_we    = 1'b0;
        ram_waddr = r_widx[3:0];
        ram_wdata = '0;
        ram_raddr = '0;

        case (r_state)
            hs1e_pkg::S_IDLE: begin
                if (i_in_valid && (i_in_data.byte_present || i_in_data.last)) begin
                    n_item = i_in_data;
                    if (!r_started) begin
                        n_started = 1'b1;
                        n_opad    = 1'b0;
                        n_widx    = '0;
                        n_ret     = hs1e_pkg::S_BYTE;
                        n_state   = hs1e_pkg::S_KEY;
                    end else begin
                        n_state = hs1e_pkg::S_BYTE;
                    end
                end
            end

            // Write key XOR pad, restarting the chain from the initial values.
            hs1e_pkg::S_KEY: begin
                ram_we    = 1'b1;
                ram_wdata = key_half ^ pad_val;
                if (r_widx == 5'd0) begin
                    n_chain = '{hs1e_pkg::IV0, hs1e_pkg::IV1, hs1e_pkg::IV2,
                                hs1e_pkg::IV3, hs1e_pkg::IV4};
                end
                n_widx = r_widx + 5'd1;
                if (r_widx == 5'd15) begin
                    n_widx  = '0;
                    n_state = hs1e_pkg::S_CPRE;
                end
            end

            // Absorb one byte; a completed word goes to the block memory.
            hs1e_pkg::S_BYTE: begin
                if (r_item.byte_present) begin
                    n_cnt = cnt_inc;
                    if (pos[1:0] == 2'd3) begin
                        ram_we    = 1'b1;
                        ram_waddr = pos[5:2];
                        ram_wdata = r_acc | byte_word;
                        n_acc     = '0;
                    end else begin
                        n_acc = r_acc | byte_word;
                    end
                end
                n_state = r_item.last ? hs1e_pkg::S_PAD : hs1e_pkg::S_IDLE;
                if (r_item.byte_present && cnt_inc[5:0] == 6'd0) begin
                    n_ret   = n_state;
                    n_state = hs1e_pkg::S_CPRE;
                end
            end

            // Close the partial word with the 0x80 marker.
            hs1e_pkg::S_PAD: begin
                ram_we    = 1'b1;
                ram_waddr = pos[5:2];
                ram_wdata = r_acc | (32'h80000000 >> {pos[1:0], 3'b000});
                n_acc     = '0;
                n_widx    = {1'b0, pos[5:2]} + 5'd1;
                n_zlim    = (pos[5:3] == 3'b111) ? 4'd15 : 4'd13;
                n_state   = hs1e_pkg::S_ZERO;
            end

            // Zero fill up to the limit; a full block is compressed first.
            hs1e_pkg::S_ZERO: begin
                if (r_widx <= {1'b0, r_zlim}) begin
                    ram_we = 1'b1;
                    n_widx = r_widx + 5'd1;
                end else if (r_zlim == 4'd15) begin
                    n_widx  = '0;
                    n_zlim  = 4'd13;
                    n_ret   = hs1e_pkg::S_ZERO;
                    n_state = hs1e_pkg::S_CPRE;
                end else begin
                    n_state = hs1e_pkg::S_LEN;
                end
            end

            // Bit length in the last two words.
            hs1e_pkg::S_LEN: begin
                ram_we    = 1'b1;
                ram_wdata = r_widx[0] ? len64[31:0] : len64[63:32];
                n_widx    = r_widx + 5'd1;
                if (r_widx[0]) begin
                    n_ret   = hs1e_pkg::S_INNER;
                    n_state = hs1e_pkg::S_CPRE;
                end
            end

            hs1e_pkg::S_INNER: begin
                n_inner = r_chain;
                n_opad  = 1'b1;
                n_widx  = '0;
                n_ret   = hs1e_pkg::S_OTAIL;
                n_state = hs1e_pkg::S_KEY;
            end

            // Outer block: inner digest, marker, zeros and fixed length.
            hs1e_pkg::S_OTAIL: begin
                ram_we = 1'b1;
                if (r_widx < 5'd5) begin
                    ram_wdata = r_inner[r_widx[2:0]];
                end else if (r_widx == 5'd5) begin
                    ram_wdata = hs1e_pkg::PAD_WORD;
                end else if (r_widx == 5'd15) begin
                    ram_wdata = hs1e_pkg::OUTER_LEN;
                end
                n_widx = r_widx + 5'd1;
                if (r_widx == 5'd15) begin
                    n_ret   = hs1e_pkg::S_OUT;
                    n_oidx  = '0;
                    n_state = hs1e_pkg::S_CPRE;
                end
            end

            // Start a compression: read word 0 and load the working variables.
            hs1e_pkg::S_CPRE: begin
                ram_raddr = '0;
                n_round   = '0;
                n_a       = r_chain[0];
                n_b       = r_chain[1];
                n_c       = r_chain[2];
                n_d       = r_chain[3];
                n_e       = r_chain[4];
                n_state   = hs1e_pkg::S_COMP;
            end

            // One round per cycle; the schedule window shifts alongside.
            hs1e_pkg::S_COMP: begin
                ram_raddr = r_round[3:0] + 4'd1;
                n_a = t_sum;
                n_b = r_a;
                n_c = {r_b[1:0], r_b[31:2]};
                n_d = r_c;
                n_e = r_d;
                for (int i = 0; i < 15; i++) begin
                    n_win[i] = r_win[i+1];
                end
                n_win[15] = w_new;
                n_round   = r_round + 7'd1;
                if (r_round == 7'(hs1e_pkg::ROUNDS - 1)) begin
                    n_state = hs1e_pkg::S_CADD;
                end
            end

            hs1e_pkg::S_CADD: begin
                n_chain[0] = r_chain[0] + r_a;
                n_chain[1] = r_chain[1] + r_b;
                n_chain[2] = r_chain[2] + r_c;
                n_chain[3] = r_chain[3] + r_d;
                n_chain[4] = r_chain[4] + r_e;
                n_state    = r_ret;
            end

            // Deliver the five digest words, then rearm for a new message.
            hs1e_pkg::S_OUT: begin
                if (!i_out_stall) begin
                    if (r_oidx == 3'd4) begin
                        n_chain   = '{hs1e_pkg::IV0, hs1e_pkg::IV1, hs1e_pkg::IV2,
                                      hs1e_pkg::IV3, hs1e_pkg::IV4};
                        n_cnt     = '0;
                        n_started = 1'b0;
                        n_oidx    = '0;
                        n_state   = hs1e_pkg::S_IDLE;
                    end else begin
                        n_oidx = r_oidx + 3'd1;
                    end
                end
            end

            default: begin
                n_state = hs1e_pkg::S_IDLE;
            end
        endcase
    end

endmodule

### hw/rtl/hs1e_checker.sv
`include "hmac_sha1_engine_macros.svh"

module hs1e_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           o_in_stall,
    input logic           o_out_valid,
    input logic           i_out_stall,
    input hs1e_pkg::t_out o_out_data
);

    // A stalled digest word stays offered.
    `HS1E_ASSERT(a_out_hold, o_out_valid && i_out_stall |=> o_out_valid, "output item dropped")

    // A stalled digest word keeps its value.
    `HS1E_ASSERT(a_out_stable, o_out_valid && i_out_stall |=> $stable(o_out_data), "output changed")

    // No new item is taken while digest words are still being delivered.
    `HS1E_ASSERT(a_no_overlap, o_out_valid |-> o_in_stall, "input accepted during output")

    // Reset leaves no result pending and the input open.
    `HS1E_ASSERT_ALWAYS(a_reset, !i_rst_n |=> !o_out_valid && !o_in_stall, "bad reset state")

endmodule

bind hmac_sha1_engine hs1e_checker u_hs1e_checker (.*);
